FILE: rtl/saf_pkg.sv
// Package for the stateful ACL firewall core: payload structs, flag layout, FSM states.
// No dependencies.
package saf_pkg;

  localparam int unsigned FlagW = 7;

  typedef enum logic {
    OP_CLASSIFY = 1'b0,
    OP_RULE_WR  = 1'b1
  } op_e;

  typedef struct packed {
    logic        operation;
    logic [3:0]  rule_index;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_portnum;
    logic [15:0] dst_portnum;
    logic [3:0]  compare_mask;
    logic        est_check;
    logic        est_wanted;
    logic        drop_action;
  } in_item_t;

  typedef struct packed {
    logic       verdict;
    logic       rule_hit;
    logic [3:0] hit_index;
    logic       conn_added;
    logic       table_full;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_REV,
    ST_RULE,
    ST_INSERT,
    ST_OUT
  } state_e;

endpackage

FILE: rtl/saf_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read data.
// No dependencies.
module saf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/stateful_acl_firewall_core.sv
// Stateful first-match ACL firewall core: top level and sequencer.
// Depends on saf_pkg and saf_ram (rule and connection memories).
//
// Usage: in_valid_i/in_stall_o carry one in_item_t beat per flow or rule write;
// out_valid_o/out_stall_i carry one out_item_t result beat per input beat.
// cfg_we_i/cfg_wdata_i write active_rules (saturated to RULE_SLOTS); the user must
// write it only while idle, the block itself does not enforce this. A rule write
// is written on acceptance and goes through ST_OUT to its result. A classify beat
// scans the connection memory twice (forward, then reversed flow), one entry per
// cycle over the conn_count stored entries, then walks the active rules one per
// cycle, then appends a new passed flow; the single read port of each memory sets
// this pace. One item is in work at a time; a new beat is taken only once the
// previous result has left. Reset clears the connection count, active_rules, the
// FSM state and the valid flags; rule and connection memories are not cleared
// (rules must be written before use). While the receiver stalls the result holds
// in the output register and no new beat is accepted.
module stateful_acl_firewall_core import saf_pkg::*; #(
  parameter int unsigned RULE_SLOTS = 16,
  parameter int unsigned CONN_SLOTS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [4:0] cfg_wdata_i
);
  localparam int unsigned RAW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CAW = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
  localparam int unsigned CCW = $clog2(CONN_SLOTS + 1);
  localparam int unsigned RCW = $clog2(RULE_SLOTS + 1);
  localparam int unsigned RDEP = (RULE_SLOTS > 1) ? RULE_SLOTS : 2;
  localparam int unsigned CDEP = (CONN_SLOTS > 1) ? CONN_SLOTS : 2;
  localparam int unsigned RuleW = 96 + FlagW;

  state_e state_q, state_d;
  in_item_t item_q;
  out_item_t res_q, res_d;
  logic [RCW-1:0] act_q;
  logic [CCW-1:0] cnt_q, cnt_d;
  logic [CCW-1:0] ci_q, ci_d;
  logic [RCW-1:0] ri_q, ri_d;
  logic fwd_q, fwd_d, rev_q, rev_d, rvld_q, rvld_d;
  logic outv_q, outv_d;

  // rule memory
  logic rwe;
  logic [RAW-1:0] rwaddr, rraddr;
  logic [RuleW-1:0] rwdata, rrdata;
  // connection memory
  logic cwe;
  logic [CAW-1:0] cwaddr, craddr;
  logic [95:0] cwdata, crdata;

  saf_ram #(.Width(RuleW), .Depth(RDEP)) u_rule_ram (
    .clk_i, .we_i(rwe), .waddr_i(rwaddr), .wdata_i(rwdata),
    .raddr_i(rraddr), .rdata_o(rrdata)
  );
  saf_ram #(.Width(96), .Depth(CDEP)) u_conn_ram (
    .clk_i, .we_i(cwe), .waddr_i(cwaddr), .wdata_i(cwdata),
    .raddr_i(craddr), .rdata_o(crdata)
  );

  logic accept;
  // hold off new beats while an item is in work or the previous result waits
  assign in_stall_o  = (state_q != ST_IDLE) || outv_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = outv_q;
  assign out_data_o  = res_q;

  logic [95:0] fkey, rkey;
  assign fkey = {item_q.src_addr, item_q.dst_addr, item_q.src_portnum, item_q.dst_portnum};
  assign rkey = {item_q.dst_addr, item_q.src_addr, item_q.dst_portnum, item_q.src_portnum};

  // rule fields from memory
  logic [31:0] r_sa, r_da;
  logic [15:0] r_sp, r_dp;
  logic [FlagW-1:0] r_f;
  assign {r_sa, r_da, r_sp, r_dp, r_f} = rrdata;

  logic rmatch;
  always_comb begin
    rmatch = 1'b1;
    if (r_f[0] && r_sa != item_q.src_addr) rmatch = 1'b0;
    if (r_f[1] && r_da != item_q.dst_addr) rmatch = 1'b0;
    if (r_f[2] && r_sp != item_q.src_portnum) rmatch = 1'b0;
    if (r_f[3] && r_dp != item_q.dst_portnum) rmatch = 1'b0;
    if (rmatch && r_f[4]) rmatch = fwd_q || (rev_q == r_f[5]);
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    ci_d    = ci_q;
    ri_d    = ri_q;
    fwd_d   = fwd_q;
    rev_d   = rev_q;
    rvld_d  = 1'b0;
    outv_d  = outv_q;
    rwe     = 1'b0;
    rwaddr  = RAW'(in_data_i.rule_index);
    rwdata  = {in_data_i.src_addr, in_data_i.dst_addr, in_data_i.src_portnum,
               in_data_i.dst_portnum, in_data_i.drop_action, in_data_i.est_wanted,
               in_data_i.est_check, in_data_i.compare_mask};
    rraddr  = ri_q[RAW-1:0];
    cwe     = 1'b0;
    cwaddr  = cnt_q[CAW-1:0];
    cwdata  = fkey;
    craddr  = ci_q[CAW-1:0];
    if (outv_q && !out_stall_i) outv_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          ci_d  = '0;
          ri_d  = '0;
          fwd_d = 1'b0;
          rev_d = 1'b0;
          if (in_data_i.operation == OP_RULE_WR) begin
            rwe = ({{(32-4){1'b0}}, in_data_i.rule_index} < 32'(RULE_SLOTS));
            state_d = ST_OUT;
          end else begin
            state_d = ST_FWD;
          end
        end
      end
      // scan stored entries; rvld_q marks data of entry ci_q-1
      ST_FWD, ST_REV: begin
        if (rvld_q) begin
          if (state_q == ST_FWD) begin
            if (crdata == fkey) fwd_d = 1'b1;
          end else if (crdata == rkey) rev_d = 1'b1;
        end
        if (ci_q < cnt_q) begin
          rvld_d = 1'b1;
          ci_d   = ci_q + 1'b1;
        end else if (!rvld_q) begin
          ci_d    = '0;
          state_d = (state_q == ST_FWD) ? ST_REV : ST_RULE;
        end
      end
      ST_RULE: begin
        if (rvld_q && rmatch) begin
          res_d.rule_hit  = 1'b1;
          res_d.hit_index = 4'((ri_q - 1'b1));
          res_d.verdict   = !r_f[6];
          state_d = (!r_f[6] && !fwd_q) ? ST_INSERT : ST_OUT;
        end else if (ri_q < act_q) begin
          rvld_d = 1'b1;
          ri_d   = ri_q + 1'b1;
        end else if (!rvld_q) begin
          state_d = ST_OUT;
        end
      end
      ST_INSERT: begin
        if (cnt_q < CCW'(CONN_SLOTS)) begin
          cwe = 1'b1;
          cnt_d = cnt_q + 1'b1;
          res_d.conn_added = 1'b1;
        end else begin
          res_d.table_full = 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!outv_q) begin
          outv_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      outv_q  <= 1'b0;
      cnt_q   <= '0;
      act_q   <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      outv_q  <= outv_d;
      cnt_q   <= cnt_d;
      rvld_q  <= rvld_d;
      if (cfg_we_i) begin
        act_q <= (32'(cfg_wdata_i) > 32'(RULE_SLOTS)) ? RCW'(RULE_SLOTS)
                                                     : RCW'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    res_q <= res_d;
    ci_q  <= ci_d;
    ri_q  <= ri_d;
    fwd_q <= fwd_d;
    rev_q <= rev_d;
  end
endmodule
